FILE: rtl/assert_macros.svh
// Assertion macros shared by the phased pattern burst PWM RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted (active-low reset).
`define PPB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define PPB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/ppb_pkg.sv
// Package for the phased pattern burst PWM: sizes, codes, reset values and pattern ROM.
// No dependencies; used by the stream interfaces and the top level.
`timescale 1ns / 1ps

package ppb_pkg;

  // Channel count and derived index width
  localparam int unsigned NUM_CHANNELS = 8;
  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Payload widths
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned CHANNEL_W = 4;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned PINS_W    = 8;
  localparam int unsigned FAST_W    = 11;
  localparam int unsigned OFFSET_W  = 5;
  localparam int unsigned OFFSETS_W = 40;

  // Pattern geometry
  localparam int unsigned AC_STEPS  = 20;
  localparam int unsigned PATTERN_W = 20;
  localparam int unsigned ROM_DEPTH = 21;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned FAST_SHIFT = 10;

  // Divider geometry: dividend below 2^27, quotient below 2^11
  localparam int unsigned DVD_W = 27;
  localparam int unsigned QUO_W = 11;
  localparam int unsigned REM_W = 16;
  localparam int unsigned CNT_W = 4;

  // Configuration port
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 64;

  // Register reset values
  localparam logic [VALUE_W-1:0]   PWM_MIN_RST = 16'd0;
  localparam logic [VALUE_W-1:0]   PWM_MAX_RST = 16'd1000;
  localparam logic [PINS_W-1:0]    AC_MASK_RST = 8'd63;
  localparam logic [OFFSETS_W-1:0] OFFSETS_RST = 40'd168274080;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_READ = 2'd2,
    OP_BAD  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_PWM_MIN = 2'd0,
    REG_PWM_MAX = 2'd1,
    REG_AC_MASK = 2'd2,
    REG_OFFSETS = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DIV,
    S_RESULT
  } state_e;

  // On/off burst patterns, one per rounded step 0..20
  localparam logic [PATTERN_W-1:0] PATTERN_ROM [ROM_DEPTH] = '{
    20'h00000,
    20'h00001, 20'h00003, 20'h00007, 20'h0000F,
    20'h0001F, 20'h01C07, 20'h01C0F, 20'h03C0F,
    20'h03C1F, 20'h07C1F, 20'h07C3F, 20'h0FC3F,
    20'h0FC7F, 20'h1FC7F, 20'h07FFF, 20'h0FFFF,
    20'h1FFFF, 20'h3FFFF, 20'h7FFFF, 20'hFFFFF
  };

endpackage

FILE: rtl/ppb_stream_if.sv
// Valid/ready stream interfaces for the command and result channels.
// Depends on ppb_pkg for payload widths.
`timescale 1ns / 1ps

interface ppb_in_if;
  import ppb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [CHANNEL_W-1:0] channel;
  logic [VALUE_W-1:0]   duty_value;

  modport source (output valid, output opcode, output channel, output duty_value,
                  input ready);
  modport sink   (input valid, input opcode, input channel, input duty_value,
                  output ready);
endinterface

interface ppb_out_if;
  import ppb_pkg::*;
  logic               valid;
  logic               ready;
  logic               status;
  logic [PINS_W-1:0]  pin_levels;
  logic [FAST_W-1:0]  fast_duty;
  logic [VALUE_W-1:0] read_value;

  modport source (output valid, output status, output pin_levels, output fast_duty,
                  output read_value, input ready);
  modport sink   (input valid, input status, input pin_levels, input fast_duty,
                  input read_value, output ready);
endinterface

FILE: rtl/phased_pattern_burst_pwm.sv
// Top level of the phased pattern burst PWM: command decode, tick sequencer, divider.
// Depends on ppb_pkg, ppb_stream_if and assert_macros.svh.
//
//   channel   direction  handshake        payload
//   in_i      sink       valid/ready      opcode, channel, duty_value
//   out_o     source     valid/ready      status, pin_levels, fast_duty, read_value
//   apb       slave      psel/penable     paddr, pwdata, prdata (64-bit, regs at 8*i)
//
// A tick walks the channels one per cycle through a shared mod-20 adder.
// A valid set with nonzero pwm_max runs the shared restoring divider one quotient
// bit per cycle. Other items go straight to the result state.
// Reset (rst_ni low, asynchronous) clears registers to their defaults, both stores,
// the phase counter and the held pin levels. The result sits in an output register;
// a stalled result holds the next item in its final state until the register frees.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module phased_pattern_burst_pwm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ppb_in_if.sink                      in_i,
  ppb_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppb_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppb_pkg::DATA_W-1:0]  pwdata,
  output logic [ppb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import ppb_pkg::*;

  // Configuration registers
  logic [VALUE_W-1:0]   pwm_min_q;
  logic [VALUE_W-1:0]   pwm_max_q;
  logic [PINS_W-1:0]    ac_mask_q;
  logic [OFFSETS_W-1:0] offsets_q;

  // Block state
  logic [VALUE_W-1:0]   duty_q    [NUM_CHANNELS];
  logic [PATTERN_W-1:0] pattern_q [NUM_CHANNELS];
  logic [STEP_W-1:0]    phase_q;
  logic [PINS_W-1:0]    level_q;

  // Sequencer and datapath registers
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     step_q;
  logic [CH_W-1:0]      ch_q;
  logic                 ac_q;
  logic [PINS_W-1:0]    lv_q;
  logic [REM_W-1:0]     rem_q;
  logic [QUO_W-1:0]     quo_q;
  logic                 res_status_q;
  logic [FAST_W-1:0]    res_fast_q;
  logic [VALUE_W-1:0]   res_read_q;

  // Output register
  logic                 out_valid_q;
  logic                 out_status_q;
  logic [PINS_W-1:0]    out_pins_q;
  logic [FAST_W-1:0]    out_fast_q;
  logic [VALUE_W-1:0]   out_read_q;

  logic                 cfg_wr;
  reg_idx_e             cfg_idx;
  logic                 in_fire;
  logic                 out_load;
  logic                 ch_ok;
  logic                 set_ok;
  logic [CH_W-1:0]      in_ch;
  logic                 in_ac;
  logic [DVD_W-1:0]     dividend;
  logic [OFFSET_W-1:0]  off_arr [NUM_CHANNELS];
  logic [CH_W-1:0]      tick_ch;
  logic [STEP_W:0]      phase_sum;
  logic [STEP_W-1:0]    bit_idx;
  logic                 pat_bit;
  logic [PINS_W-1:0]    lv_next;
  logic [REM_W:0]       part;
  logic [REM_W+1:0]     diff;
  logic                 q_bit;
  logic [QUO_W-1:0]     quo_final;
  logic [STEP_W-1:0]    rom_idx;
  logic                 tick_last;
  logic                 div_last;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:3]);

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_min_q <= PWM_MIN_RST;
      pwm_max_q <= PWM_MAX_RST;
      ac_mask_q <= AC_MASK_RST;
      offsets_q <= OFFSETS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PWM_MIN: pwm_min_q <= pwdata[VALUE_W-1:0];
        REG_PWM_MAX: pwm_max_q <= pwdata[VALUE_W-1:0];
        REG_AC_MASK: ac_mask_q <= pwdata[PINS_W-1:0];
        REG_OFFSETS: offsets_q <= pwdata[OFFSETS_W-1:0];
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_idx)
      REG_PWM_MIN: prdata = DATA_W'(pwm_min_q);
      REG_PWM_MAX: prdata = DATA_W'(pwm_max_q);
      REG_AC_MASK: prdata = DATA_W'(ac_mask_q);
      REG_OFFSETS: prdata = DATA_W'(offsets_q);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Command decode
  // ---------------------------------------------------------------------------
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_ch      = in_i.channel[CH_W-1:0];
  assign ch_ok      = (32'(in_i.channel) < NUM_CHANNELS);
  assign in_ac      = ac_mask_q[in_ch];
  assign set_ok     = ch_ok && (in_i.duty_value >= pwm_min_q)
                      && (in_i.duty_value <= pwm_max_q);

  // Scaled value plus half the divisor for rounding
  always_comb begin
    if (in_ac) begin
      dividend = DVD_W'({in_i.duty_value, 4'b0000}) + DVD_W'({in_i.duty_value, 2'b00})
                 + DVD_W'(pwm_max_q[VALUE_W-1:1]);
    end else begin
      dividend = DVD_W'({in_i.duty_value, {FAST_SHIFT{1'b0}}})
                 + DVD_W'(pwm_max_q[VALUE_W-1:1]);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared units: mod-20 phase adder and one restoring divider step
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      off_arr[c] = offsets_q[c*OFFSET_W +: OFFSET_W];
    end
  end

  assign tick_ch   = step_q[CH_W-1:0];
  assign phase_sum = {1'b0, phase_q} + {1'b0, off_arr[tick_ch]};

  // Fold the sum (at most 50) back into 0..19
  always_comb begin
    priority if (phase_sum >= (STEP_W+1)'(2*AC_STEPS)) begin
      bit_idx = STEP_W'(phase_sum - (STEP_W+1)'(2*AC_STEPS));
    end else if (phase_sum >= (STEP_W+1)'(AC_STEPS)) begin
      bit_idx = STEP_W'(phase_sum - (STEP_W+1)'(AC_STEPS));
    end else begin
      bit_idx = phase_sum[STEP_W-1:0];
    end
  end

  assign pat_bit   = ac_mask_q[tick_ch] && pattern_q[tick_ch][bit_idx];
  assign tick_last = (32'(tick_ch) == NUM_CHANNELS - 1);

  // Merge the current channel's bit into the levels gathered so far
  always_comb begin
    lv_next          = lv_q;
    lv_next[tick_ch] = pat_bit;
  end

  // Trial subtract of the divisor from the shifted remainder
  assign part      = {rem_q, quo_q[QUO_W-1]};
  assign diff      = {1'b0, part} - {2'b00, pwm_max_q};
  assign q_bit     = !diff[REM_W+1];
  assign quo_final = {quo_q[QUO_W-2:0], q_bit};
  assign div_last  = (step_q == CNT_W'(QUO_W - 1));
  assign rom_idx   = (quo_final > QUO_W'(AC_STEPS)) ? STEP_W'(AC_STEPS)
                                                    : quo_final[STEP_W-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign out_load = (state_q == S_RESULT) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (opcode_e'(in_i.opcode))
            OP_TICK: state_d = S_TICK;
            OP_SET:  state_d = (set_ok && (pwm_max_q != '0)) ? S_DIV : S_RESULT;
            OP_READ: state_d = S_RESULT;
            OP_BAD:  state_d = S_RESULT;
          endcase
        end
      end
      S_TICK:   if (tick_last) state_d = S_RESULT;
      S_DIV:    if (div_last) state_d = S_RESULT;
      S_RESULT: if (out_load) state_d = S_IDLE;
    endcase
  end

  // Datapath: accept, tick walk and divider iterations
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          step_q       <= '0;
          lv_q         <= '0;
          ch_q         <= in_ch;
          ac_q         <= in_ac;
          rem_q        <= dividend[DVD_W-1:QUO_W];
          quo_q        <= dividend[QUO_W-1:0];
          res_fast_q   <= '0;
          unique case (opcode_e'(in_i.opcode))
            OP_TICK: begin
              res_status_q <= 1'b0;
              res_read_q   <= '0;
            end
            OP_SET: begin
              res_status_q <= !set_ok;
              res_read_q   <= '0;
            end
            OP_READ: begin
              res_status_q <= !ch_ok;
              res_read_q   <= ch_ok ? duty_q[in_ch] : '0;
            end
            OP_BAD: begin
              res_status_q <= 1'b1;
              res_read_q   <= '0;
            end
          endcase
        end
      end
      S_TICK: begin
        lv_q   <= lv_next;
        step_q <= step_q + 1'b1;
      end
      S_DIV: begin
        if (q_bit) rem_q <= diff[REM_W-1:0];
        else       rem_q <= part[REM_W-1:0];
        quo_q  <= quo_final;
        step_q <= step_q + 1'b1;
        if (div_last && !ac_q) res_fast_q <= quo_final;
      end
      S_RESULT: ;
    endcase
  end

  // Stores, phase counter and held pin levels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        duty_q[c]    <= '0;
        pattern_q[c] <= '0;
      end
      phase_q <= '0;
      level_q <= '0;
    end else begin
      // Store the value; with zero full scale latch pattern zero at once
      if (in_fire && (opcode_e'(in_i.opcode) == OP_SET) && set_ok) begin
        duty_q[in_ch] <= in_i.duty_value;
        if (in_ac && (pwm_max_q == '0)) pattern_q[in_ch] <= PATTERN_ROM[0];
      end
      // Latch the rounded pattern when the divider finishes
      if ((state_q == S_DIV) && div_last && ac_q) begin
        pattern_q[ch_q] <= PATTERN_ROM[rom_idx];
      end
      // Publish the new levels and advance the phase after the last channel
      if ((state_q == S_TICK) && tick_last) begin
        level_q <= lv_next;
        phase_q <= (phase_q == STEP_W'(AC_STEPS - 1)) ? '0 : phase_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_pins_q   <= level_q;
      out_fast_q   <= res_fast_q;
      out_read_q   <= res_read_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.pin_levels = out_pins_q;
  assign out_o.fast_duty  = out_fast_q;
  assign out_o.read_value = out_read_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `PPB_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, in_fire |=> (state_q != S_IDLE), "stuck idle")
  `PPB_ASSERT_ALWAYS(a_phase_range, clk_i, phase_q < STEP_W'(AC_STEPS), "phase out of range")
  `PPB_ASSERT(a_level_on_tick, clk_i, rst_ni, !$stable(level_q) |-> $past(state_q == S_TICK), "stray")
  `PPB_ASSERT(a_rem_below_div, clk_i, rst_ni, (state_q == S_DIV) |-> (rem_q < pwm_max_q), "big rem")

endmodule
